// ===== src/cfc_pkg.sv =====
`timescale 1ns / 1ps

package cfc_pkg;

   // Default number of device id bytes that are compared
   localparam int ID_BYTES = 15;

   // Frame layout
   localparam logic [8:0] POS_ID_FIRST = 9'd1;
   localparam logic [8:0] POS_FOLLOW   = 9'd18;
   localparam logic [8:0] POS_CMD_HI   = 9'd26;
   localparam logic [8:0] POS_CMD_LO   = 9'd27;
   localparam logic [8:0] POS_LEN_LO   = 9'd28;
   localparam logic [8:0] POS_LEN_HI   = 9'd29;
   localparam logic [8:0] HEADER_BYTES = 9'd30;
   localparam logic [16:0] FRAME_OVERHEAD = 17'd33;
   localparam logic [15:0] LEN_MAX_PASSED = 16'd478;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Configuration register indexes
   localparam logic [1:0] CSR_ID_LOW  = 2'd0;
   localparam logic [1:0] CSR_ID_HIGH = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN = 2'd2;

   localparam logic [8:0] MAX_LEN_RESET = 9'd300;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_CRC_ERR     = 2'd1,
      ST_ID_MISMATCH = 2'd2,
      ST_TOO_LONG    = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_start;
      logic       network_link;
   } item_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  payload_byte;
      logic [8:0]  payload_index;
      status_type  frame_status;
      logic [15:0] command_code;
      logic        follow_on;
      logic [15:0] payload_length;
   } result_type;

   // One byte of the reflected CRC, unrolled over eight bits
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/command_frame_checker.sv =====
`timescale 1ns / 1ps
// Path: a word accepted on req is held in the input register, and its result is then
// held in the result register, which drives rsp; an rsp stall holds both registers.
// Throughput: one byte per cycle while rsp does not stall; bytes that give no result
// still pass through the input register.
// Reset: synchronous, active high; clears frame state, valid flags and the
// configuration registers (id 0, total length limit 300).

module command_frame_checker #(
   parameter int ID_BYTES = cfc_pkg::ID_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   // input bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_start,
   input  logic        req_network_link,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [8:0]  rsp_payload_index,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_command_code,
   output logic        rsp_follow_on,
   output logic [15:0] rsp_payload_length
);

   logic [ID_BYTES*8-1:0] id_ff;
   logic [8:0]            max_total_ff;

   logic                  in_valid_ff, in_valid_in;
   cfc_pkg::item_type     in_ff;
   logic                  advance;
   logic                  accept;

   logic                  res_valid;
   cfc_pkg::result_type   res;
   logic                  rsp_valid_ff, rsp_valid_in;
   cfc_pkg::result_type   rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff        <= '0;
         max_total_ff <= cfc_pkg::MAX_LEN_RESET;
      end else if (csr_write) begin
         for (int k = 0; k < ID_BYTES; k++) begin
            if (k < 8 && csr_index == cfc_pkg::CSR_ID_LOW) begin
               id_ff[k*8 +: 8] <= csr_data[(k%8)*8 +: 8];
            end else if (k >= 8 && csr_index == cfc_pkg::CSR_ID_HIGH) begin
               id_ff[k*8 +: 8] <= csr_data[(k%8)*8 +: 8];
            end
         end
         if (csr_index == cfc_pkg::CSR_MAX_LEN) begin
            max_total_ff <= csr_data[8:0];
         end
      end
   end

   // Handshake: the input word moves on whenever the result register has room
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_ff.in_byte      <= req_in_byte;
         in_ff.frame_start  <= req_frame_start;
         in_ff.network_link <= req_network_link;
      end
   end

   cfc_parser #(
      .ID_BYTES (ID_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .item_en   (advance),
      .item      (in_ff),
      .id_bytes  (id_ff),
      .max_total (max_total_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.result_kind;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_payload_index  = rsp_ff.payload_index;
   assign rsp_frame_status   = rsp_ff.frame_status;
   assign rsp_command_code   = rsp_ff.command_code;
   assign rsp_follow_on      = rsp_ff.follow_on;
   assign rsp_payload_length = rsp_ff.payload_length;

   // Payload words never carry an error status
   a_payload_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_kind == cfc_pkg::KIND_PAYLOAD
      |-> rsp_ff.frame_status == cfc_pkg::ST_OK)
      else $error("payload word with nonzero status");

   // Payload index stays inside the announced length
   a_index_in_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_kind == cfc_pkg::KIND_PAYLOAD
      |-> {7'h00, rsp_ff.payload_index} < rsp_ff.payload_length)
      else $error("payload index beyond length");

endmodule

// ===== src/cfc_parser.sv =====
`timescale 1ns / 1ps

module cfc_parser #(
   parameter int ID_BYTES = cfc_pkg::ID_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_en,
   input  cfc_pkg::item_type       item,
   input  logic [ID_BYTES*8-1:0]   id_bytes,
   input  logic [8:0]              max_total,
   output logic                    res_valid,
   output cfc_pkg::result_type     res
);

   localparam int IDX_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

   logic        active_ff, active_in;
   logic [8:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        id_ok_ff, id_ok_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] cmd_ff, cmd_in;
   logic        follow_ff, follow_in;
   logic [15:0] rx_crc_ff, rx_crc_in;

   logic        active;
   logic [8:0]  cur_pos;
   logic [15:0] cur_crc;
   logic        cur_id_ok;
   logic [15:0] cur_len;
   logic [15:0] cur_cmd;
   logic        cur_follow;
   logic [15:0] cur_rx_crc;
   logic [7:0]  b;
   logic [16:0] pos_wide;
   logic [16:0] body_end;
   logic        in_body;
   logic [IDX_W-1:0] id_sel;

   // Parse one byte: start flag restarts from the reset values
   always_comb begin
      active     = item.frame_start | active_ff;
      cur_pos    = item.frame_start ? 9'd0 : pos_ff;
      cur_crc    = item.frame_start ? cfc_pkg::CRC_INIT : crc_ff;
      cur_id_ok  = item.frame_start ? 1'b1 : id_ok_ff;
      cur_len    = item.frame_start ? 16'd0 : len_ff;
      cur_cmd    = item.frame_start ? 16'd0 : cmd_ff;
      cur_follow = item.frame_start ? 1'b0 : follow_ff;
      cur_rx_crc = item.frame_start ? 16'd0 : rx_crc_ff;
      b          = item.in_byte;

      pos_wide = {8'h00, cur_pos};
      body_end = {1'b0, cur_len} + {8'h00, cfc_pkg::HEADER_BYTES};
      in_body  = pos_wide < body_end;
      crc_in   = in_body ? cfc_pkg::crc_byte(cur_crc, b) : cur_crc;

      // device id compare over bytes 1..ID_BYTES
      id_sel   = IDX_W'(cur_pos - cfc_pkg::POS_ID_FIRST);
      id_ok_in = cur_id_ok;
      if (cur_pos >= cfc_pkg::POS_ID_FIRST && cur_pos <= 9'(ID_BYTES)) begin
         if (b != id_bytes[id_sel*8 +: 8]) begin
            id_ok_in = 1'b0;
         end
      end

      follow_in = cur_follow;
      cmd_in    = cur_cmd;
      len_in    = cur_len;
      rx_crc_in = cur_rx_crc;
      active_in = active;
      pos_in    = cur_pos + 9'd1;

      res_valid           = 1'b0;
      res.result_kind     = cfc_pkg::KIND_PAYLOAD;
      res.payload_byte    = 8'h00;
      res.payload_index   = 9'd0;
      res.frame_status    = cfc_pkg::ST_OK;

      if (cur_pos == cfc_pkg::POS_FOLLOW) begin
         follow_in = b[4];
      end else if (cur_pos == cfc_pkg::POS_CMD_HI) begin
         cmd_in = {b, 8'h00};
      end else if (cur_pos == cfc_pkg::POS_CMD_LO) begin
         cmd_in = {cur_cmd[15:8], b};
      end else if (cur_pos == cfc_pkg::POS_LEN_LO) begin
         len_in = {8'h00, b};
      end else if (cur_pos == cfc_pkg::POS_LEN_HI) begin
         len_in = {b, cur_len[7:0]};
         // total length formed at full width
         if (({1'b0, len_in} + cfc_pkg::FRAME_OVERHEAD) > {8'h00, max_total}) begin
            res_valid        = 1'b1;
            res.result_kind  = cfc_pkg::KIND_STATUS;
            res.frame_status = cfc_pkg::ST_TOO_LONG;
            active_in        = 1'b0;
         end
      end else if (cur_pos >= cfc_pkg::HEADER_BYTES) begin
         if (in_body) begin
            res_valid         = 1'b1;
            res.payload_byte  = b;
            res.payload_index = cur_pos - cfc_pkg::HEADER_BYTES;
         end else if (pos_wide == body_end) begin
            rx_crc_in = {8'h00, b};
         end else if (pos_wide == body_end + 17'd1) begin
            rx_crc_in = {b, cur_rx_crc[7:0]};
         end else begin
            // end byte: crc first, then id on the network link
            res_valid       = 1'b1;
            res.result_kind = cfc_pkg::KIND_STATUS;
            if (cur_rx_crc != cur_crc) begin
               res.frame_status = cfc_pkg::ST_CRC_ERR;
            end else if (item.network_link && !cur_id_ok) begin
               res.frame_status = cfc_pkg::ST_ID_MISMATCH;
            end
            active_in = 1'b0;
         end
      end

      res.command_code   = cmd_in;
      res.follow_on      = follow_in;
      res.payload_length = len_in;

      if (!active) begin
         res_valid = 1'b0;
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= 9'd0;
         crc_ff    <= cfc_pkg::CRC_INIT;
         id_ok_ff  <= 1'b1;
         len_ff    <= 16'd0;
         cmd_ff    <= 16'd0;
         follow_ff <= 1'b0;
         rx_crc_ff <= 16'd0;
      end else if (item_en && active) begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         id_ok_ff  <= id_ok_in;
         len_ff    <= len_in;
         cmd_ff    <= cmd_in;
         follow_ff <= follow_in;
         rx_crc_ff <= rx_crc_in;
      end
   end

   // A status result always closes the frame
   a_status_closes: assert property (@(posedge clock) disable iff (reset)
      item_en && res_valid && res.result_kind == cfc_pkg::KIND_STATUS |=> !active_ff)
      else $error("frame still active after status");

   // Past the header, the length has passed the total length check
   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      active_ff && pos_ff >= cfc_pkg::HEADER_BYTES |-> len_ff <= cfc_pkg::LEN_MAX_PASSED)
      else $error("payload length beyond any total length limit");

endmodule
